@@ rtl/srt_pkg.sv @@
// Shared types and constants of the shared region table.
package srt_pkg;

    localparam int ADDR_W  = 64;
    localparam int PERMS_W = 3;
    localparam int PSL_W   = 5;
    localparam int STAT_W  = 3;

    localparam logic [PSL_W-1:0] PSL_RESET = 5'd12;

    // Command codes carried on the input tuser.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result codes.
    typedef enum logic [STAT_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_CONFLICT = 3'd4,
        ST_FULL     = 3'd5,
        ST_HIT      = 3'd6,
        ST_MISS     = 3'd7
    } srt_status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_END,
        S_REPLY
    } srt_state_t;

    // One stored region.
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  len;
        logic [PERMS_W-1:0] rights;
    } srt_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load;
        logic        scan_clear;
        logic        issue;
        logic        set_result;
        srt_status_t result_code;
        logic        append;
        logic        out_load;
    } srt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic        is_lookup;
        logic        bad_region;
        logic        overflow;
        logic        empty;
        logic        full;
        logic        cmp_valid;
        logic        cmp_match;
        srt_status_t cmp_code;
        logic        cmp_last;
        logic        out_busy;
    } srt_stat_t;

endpackage

@@ rtl/shared_region_table_unit.sv @@
// Top level of the shared region table: a table of address regions with insert and lookup.
//
// Input items arrive on the s_ stream. s_tuser carries the command (insert or lookup);
// s_tdata carries the address, the region size and the permission bits. Each item yields
// exactly one result item on the m_ stream: m_tuser holds the status code and m_tdata the
// base, size and permissions of the matching entry on a lookup hit (zero otherwise).
// The page size used for alignment checks is set through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, as the block itself does not enforce this.
// One item is handled at a time. An insert that fails its region checks is answered from
// the check state, and on an empty table the item goes from the check state to the end
// state. Otherwise the stored regions are read one per cycle from the region memory, each
// is compared in the cycle after its read, and the scan stops at the first match. The next
// item is accepted in the cycle after the result is loaded into the output register.
// Reset clears the entry count and the page size returns to 4 KiB; region storage is not
// cleared, since only entries below the count are read. The result sits in an output
// register, so a stalled receiver holds the next result back only once that register is
// full; a new item is still accepted while a finished result waits in that register.
module shared_region_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: page size log2.
    input  logic                        cfg_wr_en,
    input  logic [srt_pkg::PSL_W-1:0]   cfg_wr_data,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [135:0]                s_tdata,   // address[63:0], size[127:64], perms[130:128], zero pad
    input  logic [0:0]                  s_tuser,   // command[0]
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [135:0]                m_tdata,   // found_base[63:0], found_size[127:64], found_perms[130:128], zero pad
    output logic [2:0]                  m_tuser    // status[2:0]
);
    import srt_pkg::*;

    srt_cmd_t           cmd;
    srt_stat_t          stat;
    logic [STAT_W-1:0]  out_status;
    logic [ADDR_W-1:0]  out_base;
    logic [ADDR_W-1:0]  out_size;
    logic [PERMS_W-1:0] out_perms;

    // Sequencing of checks, scan and append.
    srt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Region store, compares and result register.
    srt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_command  (s_tuser[0]),
        .in_address  (s_tdata[63:0]),
        .in_size     (s_tdata[127:64]),
        .in_perms    (s_tdata[130:128]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_base    (out_base),
        .out_size    (out_size),
        .out_perms   (out_perms)
    );

    // Pack the result fields.
    assign m_tuser = out_status;
    assign m_tdata = {5'b0, out_perms, out_size, out_base};

endmodule

@@ rtl/srt_ctrl.sv @@
// Controller state machine of the shared region table.
module srt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  srt_pkg::srt_stat_t stat,
    output srt_pkg::srt_cmd_t  cmd
);
    import srt_pkg::*;

    srt_state_t state_reg;
    srt_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.result_code = ST_MISS;
        s_tready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_clear = 1'b1;
                if (!stat.is_lookup && stat.bad_region) begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = ST_INVALID;
                    state_next      = S_REPLY;
                end else if (!stat.is_lookup && stat.overflow) begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = ST_OVERFLOW;
                    state_next      = S_REPLY;
                end else if (stat.empty) begin
                    state_next = S_END;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued every cycle; each compare runs in the cycle after its read.
                cmd.issue = 1'b1;
                if (stat.cmp_valid && stat.cmp_match) begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = stat.cmp_code;
                    state_next      = S_REPLY;
                end else if (stat.cmp_valid && stat.cmp_last) begin
                    state_next = S_END;
                end
            end
            S_END: begin
                // Scan found nothing: append, refuse for lack of room, or miss.
                cmd.set_result = 1'b1;
                if (stat.is_lookup) begin
                    cmd.result_code = ST_MISS;
                end else if (stat.full) begin
                    cmd.result_code = ST_FULL;
                end else begin
                    cmd.result_code = ST_ADDED;
                    cmd.append      = 1'b1;
                end
                state_next = S_REPLY;
            end
            S_REPLY: begin
                if (!stat.out_busy || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/srt_datapath.sv @@
// Datapath of the shared region table: region store, checks, compares and result register.
module srt_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [srt_pkg::PSL_W-1:0]    cfg_wr_data,
    input  logic                         in_command,
    input  logic [srt_pkg::ADDR_W-1:0]   in_address,
    input  logic [srt_pkg::ADDR_W-1:0]   in_size,
    input  logic [srt_pkg::PERMS_W-1:0]  in_perms,
    input  logic                         m_tready,
    input  srt_pkg::srt_cmd_t            cmd,
    output srt_pkg::srt_stat_t           stat,
    output logic                         out_valid,
    output logic [srt_pkg::STAT_W-1:0]   out_status,
    output logic [srt_pkg::ADDR_W-1:0]   out_base,
    output logic [srt_pkg::ADDR_W-1:0]   out_size,
    output logic [srt_pkg::PERMS_W-1:0]  out_perms
);
    import srt_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Configuration register.
    logic [PSL_W-1:0] psl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psl_reg <= PSL_RESET;
        end else if (cfg_wr_en) begin
            psl_reg <= cfg_wr_data;
        end
    end

    // Latched request.
    logic               lookup_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  end_reg;
    logic [PERMS_W-1:0] perms_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lookup_reg <= (in_command == CMD_LOOKUP);
            addr_reg   <= in_address;
            size_reg   <= in_size;
            end_reg    <= in_address + in_size;
            perms_reg  <= in_perms;
        end
    end

    // Region checks for an insert.
    logic [ADDR_W-1:0] page_mask;
    logic              bad_region;
    logic              end_overflow;

    always_comb begin
        page_mask    = (ADDR_W'(1) << psl_reg) - ADDR_W'(1);
        bad_region   = (size_reg == '0) || ((addr_reg & page_mask) != '0)
                       || ((size_reg & page_mask) != '0);
        end_overflow = addr_reg > ~size_reg;
    end

    // Region store and fill count.
    srt_entry_t        mem [ENTRIES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  issue_idx_reg;
    logic [CNT_W-1:0]  cmp_idx_reg;
    logic              cmp_valid_reg;
    srt_entry_t        rd_data_reg;
    logic              issue_ok;

    assign issue_ok = cmd.issue && (issue_idx_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem[count_reg[IDX_W-1:0]] <= '{base: addr_reg, len: size_reg, rights: perms_reg};
        end
        if (issue_ok) begin
            rd_data_reg <= mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            issue_idx_reg <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (cmd.append) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.scan_clear) begin
                issue_idx_reg <= '0;
                cmp_valid_reg <= 1'b0;
            end else begin
                cmp_valid_reg <= issue_ok;
                if (issue_ok) begin
                    issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    cmp_idx_reg   <= issue_idx_reg;
                end
            end
        end
    end

    // Compare of the entry read last cycle against the request.
    logic [ADDR_W-1:0] entry_end;
    logic [ADDR_W-1:0] probe_off;
    logic              same_entry;
    logic              overlap;
    logic              contains;
    logic              cmp_match;
    srt_status_t       cmp_code;

    always_comb begin
        entry_end  = rd_data_reg.base + rd_data_reg.len;
        probe_off  = addr_reg - rd_data_reg.base;
        same_entry = (rd_data_reg.base == addr_reg) && (rd_data_reg.len == size_reg)
                     && (rd_data_reg.rights == perms_reg);
        overlap    = (addr_reg < entry_end) && (end_reg > rd_data_reg.base);
        contains   = (addr_reg >= rd_data_reg.base) && (probe_off < rd_data_reg.len);

        if (lookup_reg) begin
            cmp_match = contains;
            cmp_code  = ST_HIT;
        end else if (same_entry) begin
            cmp_match = 1'b1;
            cmp_code  = ST_PRESENT;
        end else begin
            cmp_match = overlap;
            cmp_code  = ST_CONFLICT;
        end
    end

    // Pending result, held until the output register is free.
    srt_status_t        res_status_reg;
    logic [ADDR_W-1:0]  res_base_reg;
    logic [ADDR_W-1:0]  res_size_reg;
    logic [PERMS_W-1:0] res_perms_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_result) begin
            res_status_reg <= cmd.result_code;
            if (cmd.result_code == ST_HIT) begin
                res_base_reg  <= rd_data_reg.base;
                res_size_reg  <= rd_data_reg.len;
                res_perms_reg <= rd_data_reg.rights;
            end else begin
                res_base_reg  <= '0;
                res_size_reg  <= '0;
                res_perms_reg <= '0;
            end
        end
    end

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [STAT_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]  out_base_reg;
    logic [ADDR_W-1:0]  out_size_reg;
    logic [PERMS_W-1:0] out_perms_reg;

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_base_reg   <= res_base_reg;
            out_size_reg   <= res_size_reg;
            out_perms_reg  <= res_perms_reg;
        end
    end

    // Status to the controller.
    always_comb begin
        stat.is_lookup  = lookup_reg;
        stat.bad_region = bad_region;
        stat.overflow   = end_overflow;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(ENTRIES));
        stat.cmp_valid  = cmp_valid_reg;
        stat.cmp_match  = cmp_match;
        stat.cmp_code   = cmp_code;
        stat.cmp_last   = (cmp_idx_reg + CNT_W'(1)) == count_reg;
        stat.out_busy   = out_valid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_base      = out_base_reg;
    assign out_size      = out_size_reg;
    assign out_perms     = out_perms_reg;

endmodule

@@ tb/tb_shared_region_table_unit.sv @@
// Self-checking testbench for the shared region table: insert and lookup items against a predictor.
module tb_shared_region_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import srt_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 190;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;

    // One insert or lookup item as offered on the input stream.
    typedef struct {
        logic               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  size;
        logic [PERMS_W-1:0] perms;
    } region_req_t;

    // One result item as expected on the output stream.
    typedef struct {
        srt_status_t        status;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  size;
        logic [PERMS_W-1:0] perms;
    } region_reply_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [PSL_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [135:0]         s_tdata     = '0;   // address[63:0], size[127:64], perms[130:128], pad
    logic [0:0]           s_tuser     = '0;   // command[0]
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [135:0]         m_tdata;            // found_base[63:0], found_size[127:64],
                                              // found_perms[130:128], pad
    logic [2:0]           m_tuser;            // status[2:0]

    // Items waiting to be offered, and results waiting to arrive.
    region_req_t          request_q[$];
    region_reply_t        reply_q[$];

    // Shadow copy of the region table and the page size.
    logic [ADDR_W-1:0]    tbl_base[ENTRIES];
    logic [ADDR_W-1:0]    tbl_len[ENTRIES];
    logic [PERMS_W-1:0]   tbl_rights[ENTRIES];
    int                   tbl_count  = 0;
    logic [PSL_W-1:0]     page_shift = PSL_RESET;

    int                   errors       = 0;
    int                   results_seen = 0;
    int                   idle_cycles  = 0;

    // Sender burst state.
    int                   gap_left   = 0;
    int                   burst_left = 0;
    logic                 offer;

    // Receiver stall state.
    int                   seg_left  = 0;
    int                   seg_mode  = 0;
    int                   hold_left = 0;
    logic                 hold_done = 1'b0;
    logic                 rdy;

    shared_region_table_unit #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Apply one accepted item to the shadow table and return the result it should produce.
    function automatic region_reply_t region_table_apply(region_req_t r);
        region_reply_t y;
        logic [ADDR_W-1:0] mask;
        logic              done;
        int                i;
        y.base  = '0;
        y.size  = '0;
        y.perms = '0;
        done    = 1'b0;
        mask    = (64'd1 << page_shift) - 64'd1;
        if (r.cmd == CMD_LOOKUP) begin
            y.status = ST_MISS;
            for (i = 0; i < tbl_count && !done; i++) begin
                if (r.addr >= tbl_base[i] && r.addr - tbl_base[i] < tbl_len[i]) begin
                    y.status = ST_HIT;
                    y.base   = tbl_base[i];
                    y.size   = tbl_len[i];
                    y.perms  = tbl_rights[i];
                    done     = 1'b1;
                end
            end
        end else if (r.size == '0 || (r.addr & mask) != '0 || (r.size & mask) != '0) begin
            y.status = ST_INVALID;
        end else if (r.addr > ~r.size) begin
            // The end of the region would pass the top of the address space.
            y.status = ST_OVERFLOW;
        end else begin
            y.status = ST_ADDED;
            for (i = 0; i < tbl_count && !done; i++) begin
                if (tbl_base[i] == r.addr && tbl_len[i] == r.size && tbl_rights[i] == r.perms) begin
                    y.status = ST_PRESENT;
                    done     = 1'b1;
                end else if (r.addr < tbl_base[i] + tbl_len[i] &&
                             r.addr + r.size > tbl_base[i]) begin
                    y.status = ST_CONFLICT;
                    done     = 1'b1;
                end
            end
            if (!done) begin
                if (tbl_count >= ENTRIES) begin
                    y.status = ST_FULL;
                end else begin
                    tbl_base[tbl_count]   = r.addr;
                    tbl_len[tbl_count]    = r.size;
                    tbl_rights[tbl_count] = r.perms;
                    tbl_count++;
                end
            end
        end
        return y;
    endfunction

    // Build a random item, mostly aimed at stored regions and well-formed inserts.
    function automatic region_req_t random_request();
        region_req_t       r;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] raw;
        int                pick;
        int                slot;
        mask    = (64'd1 << page_shift) - 64'd1;
        raw     = {$urandom, $urandom};
        r.cmd   = ($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_LOOKUP;
        r.addr  = raw;
        r.size  = {$urandom, $urandom};
        r.perms = PERMS_W'($urandom_range(0, 7));
        slot    = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
        pick    = $urandom_range(0, 9);
        if (r.cmd == CMD_LOOKUP) begin
            // Probe the edges and the inside of a stored region, or a random address.
            if (tbl_count > 0 && pick < 7) begin
                case (pick)
                    0: r.addr = tbl_base[slot];
                    1: r.addr = tbl_base[slot] + tbl_len[slot] - 64'd1;
                    2: r.addr = tbl_base[slot] + tbl_len[slot];
                    3: r.addr = tbl_base[slot] - 64'd1;
                    default: r.addr = tbl_base[slot] + (raw % tbl_len[slot]);
                endcase
            end else if (pick == 7) begin
                r.addr = raw & 64'hFF_FFFF;
            end
        end else begin
            case (pick)
                0, 1: begin
                    // Same range as a stored region: identical, or with other rights.
                    if (tbl_count > 0) begin
                        r.addr = tbl_base[slot];
                        r.size = tbl_len[slot];
                        if (pick == 0) begin
                            r.perms = tbl_rights[slot];
                        end
                    end
                end
                2: begin
                    // Raw values are almost always misaligned.
                end
                3: begin
                    // Aligned region high in the address space with a huge size.
                    r.addr = (raw | 64'hF000_0000_0000_0000) & ~mask;
                    r.size = ({$urandom, $urandom} | 64'h8000_0000_0000_0000) & ~mask;
                end
                4, 5, 6: begin
                    // Small regions in a narrow window, so neighbors collide often.
                    r.addr = (raw & 64'hFF_FFFF) & ~mask;
                    r.size = 64'($urandom_range(1, 8)) << page_shift;
                end
                7, 8: begin
                    r.addr = raw & ~mask;
                    r.size = 64'($urandom_range(1, 16)) << page_shift;
                end
                default: begin
                    r.addr = raw & ~mask;
                    r.size = '0;
                end
            endcase
        end
        return r;
    endfunction

    // Compare one field of a result against its expectation.
    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // Queue an item, keeping only a few ahead of the block so targeting stays current.
    task automatic send(input logic cmd, input logic [63:0] addr, input logic [63:0] size,
                        input logic [2:0] perms);
        region_req_t r;
        r.cmd   = cmd;
        r.addr  = addr;
        r.size  = size;
        r.perms = perms;
        while (request_q.size() > 4) @(negedge aclk);
        request_q = {request_q, r};
    endtask

    // Wait until every item is accepted and every result has arrived.
    task automatic drain();
        while (request_q.size() != 0 || reply_q.size() != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the page size register while the block is idle.
    task automatic write_page_shift(input logic [PSL_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        page_shift   = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Present pending items in bursts separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                reply_q = {reply_q, region_table_apply(request_q[0])};
                void'(request_q.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() > 0) begin
                    offer   = 1'b1;
                    s_tdata <= {5'b0, request_q[0].perms, request_q[0].size, request_q[0].addr};
                    s_tuser <= request_q[0].cmd;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // Check each result item and drive the receiver's stall pattern.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (reply_q.size() == 0) begin
                    $display("%0t ns: result with none expected, expected nothing, actual status %0d",
                             $time, m_tuser);
                    errors++;
                end else begin
                    check_field("status", 64'(reply_q[0].status), 64'(m_tuser));
                    check_field("found_base", reply_q[0].base, m_tdata[63:0]);
                    check_field("found_size", reply_q[0].size, m_tdata[127:64]);
                    check_field("found_perms", 64'(reply_q[0].perms), 64'(m_tdata[130:128]));
                    void'(reply_q.pop_front());
                end
            end
            // One long hold-off lets the block fill up and push back on its input.
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(1, 40);
                    seg_mode = $urandom_range(0, 2);
                end
                seg_left--;
                case (seg_mode)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 1) == 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // End the run when nothing has been accepted for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed items, then random phases over several page sizes.
    initial begin
        logic [PSL_W-1:0] plan[7];
        int               p;
        int               n;
        plan[0] = 5'd12;
        plan[1] = 5'd16;
        plan[2] = 5'd14;
        plan[3] = 5'd0;
        plan[4] = 5'd13;
        plan[5] = 5'd31;
        plan[6] = 5'd15;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Page size from reset: 4 KiB.
        send(CMD_LOOKUP, 64'h0, 64'h0, 3'd0);                        // empty table
        send(CMD_INSERT, 64'h1000, 64'h1000, 3'd5);                  // added
        send(CMD_INSERT, 64'h1000, 64'h1000, 3'd5);                  // identical entry
        send(CMD_INSERT, 64'h1000, 64'h1000, 3'd3);                  // overlap, other rights
        send(CMD_INSERT, 64'h1800, 64'h1000, 3'd1);                  // misaligned base
        send(CMD_INSERT, 64'h2000, 64'h0, 3'd1);                     // zero size
        send(CMD_INSERT, 64'h2000, 64'h1001, 3'd1);                  // misaligned size
        send(CMD_INSERT, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 3'd6);   // end exactly 2^64
        send(CMD_INSERT, 64'hFFFF_FFFF_FFFF_E000, 64'h1000, 3'd6);   // last page that fits
        send(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 3'd7);      // covers all but the last page
        send(CMD_INSERT, 64'h3000, 64'h1000, 3'd7);                  // touching neighbors
        send(CMD_INSERT, 64'h2000, 64'h1000, 3'd0);
        send(CMD_LOOKUP, 64'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7);
        send(CMD_LOOKUP, 64'h0FFF, 64'h0, 3'd0);
        send(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 3'd0);
        send(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_EFFF, 64'h0, 3'd0);
        drain();

        // 64 KiB pages.
        write_page_shift(5'd16);
        send(CMD_INSERT, 64'h1_0000, 64'h1000, 3'd2);                // size below a page
        send(CMD_INSERT, 64'h1_8000, 64'h1_0000, 3'd2);              // base below a page
        send(CMD_INSERT, 64'h1_0000, 64'h1_0000, 3'd2);
        send(CMD_LOOKUP, 64'h1_FFFF, 64'h0, 3'd0);
        drain();

        // A zero register value means one-byte pages.
        write_page_shift(5'd0);
        send(CMD_INSERT, 64'h5, 64'h3, 3'd1);
        send(CMD_INSERT, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 3'd1);      // end past the top
        send(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd4);      // fits, overlaps all
        send(CMD_LOOKUP, 64'h7, 64'h0, 3'd0);
        send(CMD_LOOKUP, 64'h8, 64'h0, 3'd0);
        drain();

        // Random phases, one per page size setting.
        for (p = 0; p < 7; p++) begin
            write_page_shift(plan[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                while (request_q.size() > 4) @(negedge aclk);
                request_q = {request_q, random_request()};
            end
            drain();
        end

        repeat (30) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
